// ===== hdl/b36enc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-36 encoder package
// Shared widths, codes, types and arithmetic helpers for the base-36 digit
// encoder.
// ----------------------------------------------------------------------------
package b36enc_pkg;

  localparam int VALUE_W         = 64;
  localparam int BYTES_PER_VALUE = VALUE_W / 8;
  localparam int DIG_W           = 6;
  localparam int CAR_W           = 8;
  localparam int ACC_W           = DIG_W + CAR_W;
  localparam int CHAR_W          = 7;
  localparam int TOP_W           = 4;
  localparam int POW_W           = 68;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_DIGIT_INDEX    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LEADING_ZEROS = 4'd1;
  localparam logic [TOP_W-1:0]     TOP_RST                = 4'd9;
  localparam logic                 TRIM_RST               = 1'b1;

  // Division by 36 through a reciprocal: exact for every dividend below 36 * 256.
  localparam int          RECIP_SH = 18;
  localparam logic [26:0] RECIP_36 = 27'd7282;

  localparam logic [CHAR_W-1:0] ASCII_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_OFS = 7'd55;
  localparam logic [DIG_W-1:0]  DECIMAL_LIMIT   = 6'd10;

  typedef logic [DIG_W-1:0] dig_t;
  typedef logic [CAR_W-1:0] car_t;

  typedef struct packed {
    logic ovf;
    logic zero;
  } tag_t;

  // What one cell hands to its upper neighbor each cycle.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    car_t car;
    tag_t tag;
  } tok_t;

  typedef struct packed {
    car_t q;
    dig_t rem;
  } divres_t;

  function automatic divres_t div36(input logic [ACC_W-1:0] t);
    logic [26:0]      prod;
    car_t             q;
    logic [ACC_W-1:0] q32;
    logic [ACC_W-1:0] q4;
    divres_t          r;
    prod  = 27'(t) * RECIP_36;
    q     = prod[RECIP_SH+CAR_W-1:RECIP_SH];
    q32   = {1'b0, q, 5'b0};
    q4    = {4'b0, q, 2'b0};
    r.q   = q;
    r.rem = DIG_W'(t - q32 - q4);
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input dig_t d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = CHAR_W'(d) + ASCII_ZERO;
    end else begin
      c = CHAR_W'(d) + ASCII_ALPHA_OFS;
    end
    return c;
  endfunction

  // 36 to the power n, for n from 1 to 13.
  function automatic logic [POW_W-1:0] pow36(input logic [TOP_W-1:0] n);
    logic [POW_W-1:0] p;
    unique case (n)
      4'd1:    p = 68'd36;
      4'd2:    p = 68'd1296;
      4'd3:    p = 68'd46656;
      4'd4:    p = 68'd1679616;
      4'd5:    p = 68'd60466176;
      4'd6:    p = 68'd2176782336;
      4'd7:    p = 68'd78364164096;
      4'd8:    p = 68'd2821109907456;
      4'd9:    p = 68'd101559956668416;
      4'd10:   p = 68'd3656158440062976;
      4'd11:   p = 68'd131621703842267136;
      4'd12:   p = 68'd4738381338321616896;
      4'd13:   p = 68'd170581728179578208256;
      default: p = 68'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/b36enc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-36 encoder input channel
// Valid/ready channel that carries one 64-bit value per transaction.
// ----------------------------------------------------------------------------
interface b36enc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== hdl/b36enc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-36 encoder result channel
// Valid/ready channel that carries one digit result per transaction.
// ----------------------------------------------------------------------------
interface b36enc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       is_last;
  logic       overflow;
  logic       no_digits;

  modport source (output valid, output digit_char, output is_last,
                  output overflow, output no_digits, input ready);
  modport sink   (input valid, input digit_char, input is_last,
                  input overflow, input no_digits, output ready);
endinterface

// ===== hdl/b36enc_loader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-36 encoder loader
// Accepts a value, flags overflow and zero, and feeds it into the cell row
// one byte per cycle while enabled, most significant byte first.
// ----------------------------------------------------------------------------
module b36enc_loader #(
  parameter int CADENCE = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [b36enc_pkg::TOP_W-1:0] top_sat,
  b36enc_in_if.sink                  in_bus,
  output b36enc_pkg::tok_t           tok_o
);
  import b36enc_pkg::*;

  // Wide enough for the last phase and for the byte count of a value.
  localparam int PH_W = $clog2(CADENCE + 1);

  logic               busy_r, busy_nxt;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [VALUE_W-1:0] shreg_r, shreg_nxt;
  tag_t               tag_r, tag_nxt;
  logic               phase_end;
  logic               accept;
  logic [TOP_W-1:0]   top_plus1;

  assign phase_end    = (phase_r == PH_W'(CADENCE - 1));
  assign in_bus.ready = en && (!busy_r || phase_end);
  assign accept       = in_bus.valid && in_bus.ready;
  assign top_plus1    = top_sat + TOP_W'(1);

  assign tok_o.vld   = busy_r && (phase_r < PH_W'(BYTES_PER_VALUE));
  assign tok_o.first = (phase_r == '0);
  assign tok_o.last  = (phase_r == PH_W'(BYTES_PER_VALUE - 1));
  assign tok_o.car   = shreg_r[VALUE_W-1 -: CAR_W];
  assign tok_o.tag   = tag_r;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    shreg_nxt = shreg_r;
    tag_nxt   = tag_r;
    if (accept) begin
      busy_nxt     = 1'b1;
      phase_nxt    = '0;
      shreg_nxt    = in_bus.value;
      tag_nxt.ovf  = ({4'b0, in_bus.value} >= pow36(top_plus1));
      tag_nxt.zero = (in_bus.value == '0);
    end else if (en && busy_r) begin
      if (phase_end) begin
        busy_nxt = 1'b0;
      end else begin
        phase_nxt = phase_r + PH_W'(1);
      end
      shreg_nxt = {shreg_r[VALUE_W-CAR_W-1:0], {CAR_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    tag_r   <= tag_nxt;
  end

endmodule

// ===== hdl/b36enc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-36 encoder cell
// Holds one base-36 digit. Each byte step multiplies the digit by 256, adds
// the carry from below, keeps the remainder by 36 and passes the quotient up.
// ----------------------------------------------------------------------------
module b36enc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  b36enc_pkg::tok_t  tok_i,
  output b36enc_pkg::tok_t  tok_o,
  output b36enc_pkg::dig_t  res_o
);
  import b36enc_pkg::*;

  dig_t    dig_r, dig_nxt;
  dig_t    res_r, res_nxt;
  tok_t    tok_r, tok_nxt;
  dig_t    base;
  divres_t dr;

  assign base = tok_i.first ? '0 : dig_r;
  assign dr   = div36({base, tok_i.car});

  always_comb begin
    dig_nxt = dig_r;
    res_nxt = res_r;
    tok_nxt = tok_r;
    if (en) begin
      tok_nxt     = tok_i;
      tok_nxt.car = dr.q;
      if (tok_i.vld) begin
        dig_nxt = dr.rem;
        if (tok_i.last) begin
          res_nxt = dr.rem;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.first <= tok_nxt.first;
    tok_r.last  <= tok_nxt.last;
    tok_r.car   <= tok_nxt.car;
    tok_r.tag   <= tok_nxt.tag;
    dig_r       <= dig_nxt;
    res_r       <= res_nxt;
  end

  assign tok_o = tok_r;
  assign res_o = res_r;

endmodule

// ===== hdl/b36enc_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-36 encoder serializer
// Takes a finished set of digits and sends them out one per transaction,
// most significant first, with leading zeros trimmed when enabled.
// ----------------------------------------------------------------------------
module b36enc_serializer #(
  parameter int DIGIT_LIMIT = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         set_vld,
  input  b36enc_pkg::tag_t             set_tag,
  input  b36enc_pkg::dig_t             set_dig [DIGIT_LIMIT],
  input  logic [b36enc_pkg::TOP_W-1:0] top_sat,
  input  logic                         trim,
  output logic                         take,
  b36enc_out_if.source                 out_bus
);
  import b36enc_pkg::*;

  localparam int IDX_W = $clog2(DIGIT_LIMIT);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic             empty_r, empty_nxt;
  dig_t             dig_r [DIGIT_LIMIT];
  logic [IDX_W-1:0] msd;
  logic             single;
  logic             done;

  always_comb begin
    msd = '0;
    for (int k = 0; k < DIGIT_LIMIT; k++) begin
      if (set_dig[k] != '0) begin
        msd = IDX_W'(k);
      end
    end
  end

  assign single = ovf_r || empty_r;

  assign out_bus.valid      = busy_r;
  assign out_bus.is_last    = single || (idx_r == '0);
  assign out_bus.overflow   = ovf_r;
  assign out_bus.no_digits  = empty_r;
  assign out_bus.digit_char = single ? '0 : digit_ascii(dig_r[idx_r]);

  assign done = out_bus.valid && out_bus.ready && out_bus.is_last;
  assign take = set_vld && (!busy_r || done);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    empty_nxt = empty_r;
    if (take) begin
      busy_nxt  = 1'b1;
      ovf_nxt   = set_tag.ovf;
      empty_nxt = !set_tag.ovf && set_tag.zero && trim;
      if (set_tag.ovf || (set_tag.zero && trim)) begin
        idx_nxt = '0;
      end else if (trim) begin
        idx_nxt = msd;
      end else begin
        idx_nxt = IDX_W'(top_sat);
      end
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (out_bus.valid && out_bus.ready) begin
      idx_nxt = idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    ovf_r   <= ovf_nxt;
    empty_r <= empty_nxt;
    if (take) begin
      dig_r <= set_dig;
    end
  end

  // Overflow and empty results stand alone and never carry a character.
  a_single_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && (out_bus.overflow || out_bus.no_digits) |->
      out_bus.is_last && (out_bus.digit_char == '0))
    else $error("overflow or empty result is not a lone, blank last result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !(out_bus.overflow && out_bus.no_digits))
    else $error("overflow and no_digits raised together");

  // A taken digit that is not the last is followed at once by the next one.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ready && !out_bus.is_last |=>
      out_bus.valid && !out_bus.overflow && !out_bus.no_digits)
    else $error("digit run broken before its last result");

  a_ovf_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    take && set_tag.ovf |=> out_bus.valid && out_bus.overflow)
    else $error("overflowed value did not produce an overflow result");

endmodule

// ===== hdl/base36_digit_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-36 digit encoder
// Converts 64-bit unsigned values to base-36 ASCII digits, most significant
// first, with optional leading-zero trimming and an overflow check.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction carries
//   -------   ---------  ----------------------------------------------------
//   in_bus    sink       value: one 64-bit unsigned number
//   out_bus   source     digit_char, is_last, overflow, no_digits: one result
//   cfg_*     write      cfg_idx selects the register, cfg_wdata the data
//
// A new value is taken as the loader ends the spacing of the previous one, so
// values overlap in the row: the row of cells takes each value one byte per
// cycle while not stalled, eight bytes in all, and the serializer sends up to
// DIGIT_LIMIT results, one per cycle while the result channel is ready.
// Reset is synchronous and active low; the configuration returns to its
// reset values and all transactions in flight are dropped.
// When a finished digit set waits on a stalled result channel, the whole
// cell row and the loader hold still until the serializer takes the set.
//
// Conversion works by Horner's rule in base 36: each byte of the value
// enters at the lowest cell, and every cell multiplies its digit by 256,
// adds the carry from the cell below, keeps the remainder by 36 and hands
// the quotient upward through a token register, one register per cell.
// As a cell handles the last byte it latches its final digit into
// a result register; once the top cell has done so, the full set is ready
// for the serializer. Each result register holds its digit for at least the
// spacing between values, which is never shorter than the row length.
//
// The overflow test compares the value against 36 to the power of the digit
// count at acceptance. An index above DIGIT_LIMIT - 1 acts as DIGIT_LIMIT - 1.
// ----------------------------------------------------------------------------
module base36_digit_encoder_unit #(
  parameter int DIGIT_LIMIT = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  b36enc_in_if.sink                         in_bus,
  b36enc_out_if.source                      out_bus,
  input  logic                              cfg_we,
  input  logic [b36enc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [b36enc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import b36enc_pkg::*;

  // Spacing between accepted values, in cycles.
  localparam int CADENCE = (DIGIT_LIMIT > BYTES_PER_VALUE) ? DIGIT_LIMIT
                                                           : BYTES_PER_VALUE;

  logic [TOP_W-1:0] cfg_top_r, cfg_top_nxt;
  logic             cfg_trim_r, cfg_trim_nxt;
  logic [TOP_W-1:0] top_sat;

  // Configuration registers. Writes to unknown indexes are dropped.
  always_comb begin
    cfg_top_nxt  = cfg_top_r;
    cfg_trim_nxt = cfg_trim_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TOP_DIGIT_INDEX:    cfg_top_nxt  = cfg_wdata[TOP_W-1:0];
        CFG_TRIM_LEADING_ZEROS: cfg_trim_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_top_r  <= TOP_RST;
      cfg_trim_r <= TRIM_RST;
    end else begin
      cfg_top_r  <= cfg_top_nxt;
      cfg_trim_r <= cfg_trim_nxt;
    end
  end

  assign top_sat = (cfg_top_r >= TOP_W'(DIGIT_LIMIT)) ? TOP_W'(DIGIT_LIMIT - 1)
                                                      : cfg_top_r;

  // Token chain: tok[0] comes from the loader, tok[k+1] from cell k.
  tok_t tok [DIGIT_LIMIT+1];
  dig_t res [DIGIT_LIMIT];
  logic chain_en;
  logic set_vld;
  logic take;

  assign set_vld  = tok[DIGIT_LIMIT].vld && tok[DIGIT_LIMIT].last;
  // The row advances unless a finished set is waiting on the serializer.
  assign chain_en = !set_vld || take;

  b36enc_loader #(
    .CADENCE (CADENCE)
  ) u_loader (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (chain_en),
    .top_sat (top_sat),
    .in_bus  (in_bus),
    .tok_o   (tok[0])
  );

  for (genvar k = 0; k < DIGIT_LIMIT; k++) begin : g_cell
    b36enc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (chain_en),
      .tok_i (tok[k]),
      .tok_o (tok[k+1]),
      .res_o (res[k])
    );
  end

  b36enc_serializer #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_serializer (
    .clk     (clk),
    .rst_n   (rst_n),
    .set_vld (set_vld),
    .set_tag (tok[DIGIT_LIMIT].tag),
    .set_dig (res),
    .top_sat (top_sat),
    .trim    (cfg_trim_r),
    .take    (take),
    .out_bus (out_bus)
  );

endmodule
